// ===== design/tspc_pkg.sv =====
// Package for the timed shutter position control block.
// Holds motion codes, input kinds, sequencer states and Q16 constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tspc_pkg;

    // Motion state codes as reported on motion_state
    typedef enum logic [2:0] {
        ST_OPEN    = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_OPENING = 3'd2,
        ST_CLOSING = 3'd3,
        ST_MIDWAY  = 3'd4
    } motion_t;

    // Input item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    // Configuration register indexes
    localparam logic CFG_OPEN_TRAVEL  = 1'b0;
    localparam logic CFG_CLOSE_TRAVEL = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        C_IDLE,
        C_DIV,
        C_APPLY,
        C_DONE
    } ctrl_t;

    localparam int POS_W     = 17;
    localparam int TRAVEL_W  = 20;
    localparam int QUOT_W    = 32;
    localparam int CNT_W     = 5;
    localparam int WIDE_W    = 34;

    localparam logic [POS_W-1:0]    Q16_ONE        = 17'h10000;
    localparam logic [TRAVEL_W-1:0] TRAVEL_DEFAULT = 20'd10000;
    localparam logic [CNT_W-1:0]    LAST_STEP      = 5'd31;

    // Result of settling a position
    typedef struct packed {
        logic [POS_W-1:0] pos;
        motion_t          motion;
    } settle_t;

endpackage

`default_nettype wire

// ===== design/timed_shutter_position_control.sv =====
// Sequence: move, stop and idle ticks go from the accepted beat straight to the done
// state, where the result is loaded into the output register. A tick while moving
// first runs the bit-serial restoring divider, then the add step, then the output load.
// A new beat is accepted only in the idle state, once the previous result has been
// loaded; that load waits while the output register is full and not taken. A finished
// result waits in the output register while the next beat is accepted.
// Reset: asynchronous, active low; position and target 0, state open, travel 10000 ms.
`timescale 1ns / 1ps
`default_nettype none

module timed_shutter_position_control
    import tspc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [TRAVEL_W-1:0] cfg_data,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          kind,
    input  wire logic [15:0]         elapsed_ms,
    input  wire logic [POS_W-1:0]    target_position,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [POS_W-1:0]         position,
    output logic [POS_W-1:0]         target_now,
    output logic [2:0]               motion_state,
    output logic                     drive_open,
    output logic                     drive_close
);

    ctrl_t                ctrl_reg, ctrl_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     tgt_reg, tgt_next;
    motion_t              motion_reg, motion_next;
    logic [TRAVEL_W-1:0]  open_travel_reg, close_travel_reg;
    logic [TRAVEL_W-1:0]  divisor_reg, divisor_next;
    logic [QUOT_W-1:0]    div_reg, div_next;
    logic [TRAVEL_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 out_valid_reg, out_valid_next;
    logic [POS_W-1:0]     position_reg, target_now_reg;
    motion_t              motion_out_reg;

    logic                 in_fire, out_free, out_load;
    logic [TRAVEL_W:0]    trial, trial_diff;
    logic                 trial_ge;
    logic [WIDE_W-1:0]    open_sum, close_diff, tgt_wide;
    logic [POS_W-1:0]     tgt_sat;
    settle_t              settle_stop, settle_open, settle_close;

    // Clamp to closed or open, else mark midway
    function automatic settle_t settle_fn(input logic [WIDE_W-1:0] v);
        settle_t r;
        if (v[WIDE_W-1] || v == '0)
        begin
            r.pos    = '0;
            r.motion = ST_CLOSED;
        end
        else if (v >= {{(WIDE_W-POS_W){1'b0}}, Q16_ONE})
        begin
            r.pos    = Q16_ONE;
            r.motion = ST_OPEN;
        end
        else
        begin
            r.pos    = v[POS_W-1:0];
            r.motion = ST_MIDWAY;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (ctrl_reg == C_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (ctrl_reg == C_DONE) && out_free;

    // One restoring division step
    assign trial      = {rem_reg, div_reg[QUOT_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});

    // Position update at the end of a moving tick
    assign tgt_wide     = {{(WIDE_W-POS_W){1'b0}}, tgt_reg};
    assign open_sum     = {{(WIDE_W-POS_W){1'b0}}, pos_reg} + {2'b00, div_reg};
    assign close_diff   = {{(WIDE_W-POS_W){1'b0}}, pos_reg} - {2'b00, div_reg};
    assign settle_stop  = settle_fn({{(WIDE_W-POS_W){1'b0}}, pos_reg});
    assign settle_open  = settle_fn(open_sum);
    assign settle_close = settle_fn(close_diff);
    assign tgt_sat      = (target_position > Q16_ONE) ? Q16_ONE : target_position;

    // Sequencer next state
    always_comb
    begin
        ctrl_next = ctrl_reg;
        case (ctrl_reg)
            C_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == KIND_TICK
                        && (motion_reg == ST_OPENING || motion_reg == ST_CLOSING))
                        ctrl_next = C_DIV;
                    else
                        ctrl_next = C_DONE;
                end
            end
            C_DIV:
            begin
                if (count_reg == LAST_STEP)
                    ctrl_next = C_APPLY;
            end
            C_APPLY:
            begin
                ctrl_next = C_DONE;
            end
            C_DONE:
            begin
                if (out_free)
                    ctrl_next = C_IDLE;
            end
            default:
            begin
                ctrl_next = C_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        pos_next     = pos_reg;
        tgt_next     = tgt_reg;
        motion_next  = motion_reg;
        divisor_next = divisor_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        case (ctrl_reg)
            C_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind)
                        KIND_TICK:
                        begin
                            // Load the divider with elapsed * 65536 over the travel time
                            if (motion_reg == ST_OPENING)
                                divisor_next = (open_travel_reg == '0) ?
                                    TRAVEL_W'(1) : open_travel_reg;
                            else
                                divisor_next = (close_travel_reg == '0) ?
                                    TRAVEL_W'(1) : close_travel_reg;
                            div_next   = {elapsed_ms, 16'h0000};
                            rem_next   = '0;
                            count_next = '0;
                        end
                        KIND_MOVE:
                        begin
                            tgt_next = tgt_sat;
                            if (tgt_sat > pos_reg)
                                motion_next = ST_OPENING;
                            else if (tgt_sat < pos_reg)
                                motion_next = ST_CLOSING;
                        end
                        KIND_STOP:
                        begin
                            pos_next    = settle_stop.pos;
                            motion_next = settle_stop.motion;
                            tgt_next    = settle_stop.pos;
                        end
                        default:
                        begin
                            // Unused kind: hold everything
                        end
                    endcase
                end
            end
            C_DIV:
            begin
                // Shift in one quotient bit per cycle
                rem_next   = trial_ge ? trial_diff[TRAVEL_W-1:0] : trial[TRAVEL_W-1:0];
                div_next   = {div_reg[QUOT_W-2:0], trial_ge};
                count_next = count_reg + CNT_W'(1);
            end
            C_APPLY:
            begin
                if (motion_reg == ST_OPENING)
                begin
                    if (open_sum >= tgt_wide)
                    begin
                        pos_next    = settle_open.pos;
                        motion_next = settle_open.motion;
                    end
                    else
                        pos_next = open_sum[POS_W-1:0];
                end
                else
                begin
                    if (close_diff[WIDE_W-1] || close_diff <= tgt_wide)
                    begin
                        pos_next    = settle_close.pos;
                        motion_next = settle_close.motion;
                    end
                    else
                        pos_next = close_diff[POS_W-1:0];
                end
            end
            default:
            begin
                // Hold while the result waits for the output register
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg         <= C_IDLE;
            pos_reg          <= '0;
            tgt_reg          <= '0;
            motion_reg       <= ST_OPEN;
            open_travel_reg  <= TRAVEL_DEFAULT;
            close_travel_reg <= TRAVEL_DEFAULT;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            ctrl_reg      <= ctrl_next;
            pos_reg       <= pos_next;
            tgt_reg       <= tgt_next;
            motion_reg    <= motion_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            // Take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OPEN_TRAVEL)
                    open_travel_reg <= cfg_data;
                else if (cfg_index == CFG_CLOSE_TRAVEL)
                    close_travel_reg <= cfg_data;
            end
        end
    end

    // Divider and result payload registers
    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        if (out_load)
        begin
            position_reg   <= pos_reg;
            target_now_reg <= tgt_reg;
            motion_out_reg <= motion_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = position_reg;
    assign target_now   = target_now_reg;
    assign motion_state = motion_out_reg;
    assign drive_open   = (motion_out_reg == ST_OPENING);
    assign drive_close  = (motion_out_reg == ST_CLOSING);

endmodule

`default_nettype wire
